/* rtl/fdsf_pkg.sv */
// Shared types and constants for the first-duplicate stream filter.
package fdsf_pkg;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUT_FIRST,
        ST_PUT_SECOND
    } fdsf_state_t;

    // Control flags of a probe travelling down the cell row.
    typedef struct packed {
        logic valid;
        logic hit;
        logic placed;
    } fdsf_tok_ctl_t;

    // Register file.
    localparam int unsigned  REG_ADDR_W     = 3;
    localparam logic [0:0]   REG_KEY_MASK   = 1'b0;
    localparam logic [31:0]  KEY_MASK_RESET = 32'hFFFF_FFFF;

endpackage

/* rtl/fdsf_cell.sv */
// One cell of the seen-value row: holds one stored value and checks each passing probe.
module fdsf_cell #(
    parameter int unsigned VW = 32,
    parameter int unsigned CW = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VW-1:0]          kmask,
    input  fdsf_pkg::fdsf_tok_ctl_t ctl_in,
    input  logic [VW-1:0]          value_in,
    input  logic [VW-1:0]          hit_value_in,
    input  logic [CW-1:0]          rem_in,
    output fdsf_pkg::fdsf_tok_ctl_t ctl_out,
    output logic [VW-1:0]          value_out,
    output logic [VW-1:0]          hit_value_out,
    output logic [CW-1:0]          rem_out
);

    logic [VW-1:0]           entry_reg;
    fdsf_pkg::fdsf_tok_ctl_t ctl_reg;
    fdsf_pkg::fdsf_tok_ctl_t ctl_next;
    logic [VW-1:0]           value_reg;
    logic [VW-1:0]           hit_value_reg;
    logic [VW-1:0]           hit_value_next;
    logic [CW-1:0]           rem_reg;
    logic [CW-1:0]           rem_next;
    logic                    occupied;
    logic                    match;
    logic                    store;

    // rem_in counts the filled cells still ahead, this one included
    assign occupied = (rem_in != '0);
    assign match    = ctl_in.valid && occupied && !ctl_in.hit
                      && ((entry_reg & kmask) == (value_in & kmask));
    assign store    = ctl_in.valid && !occupied && !ctl_in.hit && !ctl_in.placed;

    always_comb
    begin
        ctl_next.valid  = ctl_in.valid;
        ctl_next.hit    = ctl_in.hit | match;
        ctl_next.placed = ctl_in.placed | store;
        hit_value_next  = match ? entry_reg : hit_value_in;
        rem_next        = occupied ? (rem_in - CW'(1)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            entry_reg <= value_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_in;
        hit_value_reg <= hit_value_next;
        rem_reg       <= rem_next;
    end

    assign ctl_out       = ctl_reg;
    assign value_out     = value_reg;
    assign hit_value_out = hit_value_reg;
    assign rem_out       = rem_reg;

endmodule

/* rtl/first_duplicate_stream_filter.sv */
// Top level of the first-duplicate stream filter: controller, register port and cell row.
// Before a duplicate is known each item walks the whole cell row, one cell per cycle,
//   and the controller then passes its results (two results on the first match).
// Once a duplicate is latched an item is only checked against the latched key, and passes a result on a match.
// One item is in work at a time: the input stalls until the controller is idle again.
// Reset clears the flags, fill count and latched key and sets key_mask to all ones.
module first_duplicate_stream_filter #(
    parameter int unsigned STORE_DEPTH = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fdsf_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // item input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [VALUE_WIDTH-1:0]            value,
    input  logic                              seq_last,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [31:0]                       out_value,
    output logic                              run_last,
    output logic                              overflowed
);

    localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [31:0]            key_mask_reg;
    fdsf_pkg::fdsf_state_t  state_reg;
    fdsf_pkg::fdsf_state_t  state_next;
    logic [CNT_W-1:0]       seen_count_reg;
    logic [CNT_W-1:0]       seen_count_next;
    logic                   dupe_found_reg;
    logic                   dupe_found_next;
    logic [VALUE_WIDTH-1:0] dupe_key_reg;
    logic [VALUE_WIDTH-1:0] dupe_key_next;
    logic                   overflow_flag_reg;
    logic                   overflow_flag_next;
    logic [VALUE_WIDTH-1:0] item_value_reg;
    logic [VALUE_WIDTH-1:0] item_value_next;
    logic                   item_last_reg;
    logic                   item_last_next;
    logic [VALUE_WIDTH-1:0] first_value_reg;
    logic [VALUE_WIDTH-1:0] first_value_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [VALUE_WIDTH-1:0] out_value_next;
    logic                   out_run_last_reg;
    logic                   out_run_last_next;
    logic                   out_overflowed_reg;
    logic                   out_overflowed_next;

    // ------------------------------------------------------------------
    // Cell row wiring: stage 0 is the probe launched by the controller,
    // stage STORE_DEPTH is what leaves the last cell.
    // ------------------------------------------------------------------
    fdsf_pkg::fdsf_tok_ctl_t ctl_s       [0:STORE_DEPTH];
    logic [VALUE_WIDTH-1:0]  value_s     [0:STORE_DEPTH];
    logic [VALUE_WIDTH-1:0]  hit_value_s [0:STORE_DEPTH];
    logic [CNT_W-1:0]        rem_s       [0:STORE_DEPTH];

    logic [VALUE_WIDTH-1:0] kmask_w;
    logic                   in_accept;
    logic                   out_free;
    logic                   cfg_write;
    logic                   key_match;

    // ------------------------------------------------------------------
    // Configuration port: a single register, always ready
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == fdsf_pkg::REG_KEY_MASK) ? key_mask_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_mask_reg <= fdsf_pkg::KEY_MASK_RESET;
        end
        else if (cfg_write && (paddr[2] == fdsf_pkg::REG_KEY_MASK))
        begin
            key_mask_reg <= pwdata;
        end
    end

    // Fit the 32-bit key mask to the value width: upper bits beyond the
    // register take no part in the key.
    for (genvar b = 0; b < VALUE_WIDTH; b++)
    begin : g_kmask
        if (b < 32)
        begin : g_in
            assign kmask_w[b] = key_mask_reg[b];
        end
        else
        begin : g_out
            assign kmask_w[b] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != fdsf_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    // The output slot can take a new result when empty or draining now
    assign out_free  = !out_valid_reg || !out_stall;

    // Key check against the latched duplicate key, used once it is found
    assign key_match = ((value & kmask_w) == (dupe_key_reg & kmask_w));

    // ------------------------------------------------------------------
    // Probe launch: only while no duplicate is latched. The probe carries
    // the fill count, so the first empty cell it meets takes the value unless a cell matched.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctl_s[0].valid  = in_accept && !dupe_found_reg;
        ctl_s[0].hit    = 1'b0;
        ctl_s[0].placed = 1'b0;
        value_s[0]      = value;
        hit_value_s[0]  = value;
        rem_s[0]        = seen_count_reg;
    end

    for (genvar c = 0; c < STORE_DEPTH; c++)
    begin : g_cell
        fdsf_cell #(
            .VW (VALUE_WIDTH),
            .CW (CNT_W)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .kmask         (kmask_w),
            .ctl_in        (ctl_s[c]),
            .value_in      (value_s[c]),
            .hit_value_in  (hit_value_s[c]),
            .rem_in        (rem_s[c]),
            .ctl_out       (ctl_s[c+1]),
            .value_out     (value_s[c+1]),
            .hit_value_out (hit_value_s[c+1]),
            .rem_out       (rem_s[c+1])
        );
    end

    // ------------------------------------------------------------------
    // Controller: next state and next register values
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next          = state_reg;
        seen_count_next     = seen_count_reg;
        dupe_found_next     = dupe_found_reg;
        dupe_key_next       = dupe_key_reg;
        overflow_flag_next  = overflow_flag_reg;
        item_value_next     = item_value_reg;
        item_last_next      = item_last_reg;
        first_value_next    = first_value_reg;
        out_valid_next      = out_valid_reg && out_stall;
        out_value_next      = out_value_reg;
        out_run_last_next   = out_run_last_reg;
        out_overflowed_next = out_overflowed_reg;

        unique case (state_reg)
            fdsf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    item_value_next = value;
                    item_last_next  = seq_last;
                    if (!dupe_found_reg)
                    begin
                        // walk the row
                        state_next = fdsf_pkg::ST_SCAN;
                    end
                    else if (key_match)
                    begin
                        state_next = fdsf_pkg::ST_PUT_SECOND;
                    end
                    else if (seq_last)
                    begin
                        // drop the item and close the sequence
                        seen_count_next    = '0;
                        dupe_found_next    = 1'b0;
                        dupe_key_next      = '0;
                        overflow_flag_next = 1'b0;
                    end
                end
            end

            fdsf_pkg::ST_SCAN:
            begin
                if (ctl_s[STORE_DEPTH].valid)
                begin
                    if (ctl_s[STORE_DEPTH].hit)
                    begin
                        // first duplicate: latch its key, send both items
                        dupe_found_next  = 1'b1;
                        dupe_key_next    = item_value_reg & kmask_w;
                        first_value_next = hit_value_s[STORE_DEPTH];
                        state_next       = fdsf_pkg::ST_PUT_FIRST;
                    end
                    else
                    begin
                        if (ctl_s[STORE_DEPTH].placed)
                        begin
                            seen_count_next = seen_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            overflow_flag_next = 1'b1;
                        end
                        if (item_last_reg)
                        begin
                            seen_count_next    = '0;
                            dupe_found_next    = 1'b0;
                            dupe_key_next      = '0;
                            overflow_flag_next = 1'b0;
                        end
                        state_next = fdsf_pkg::ST_IDLE;
                    end
                end
            end

            fdsf_pkg::ST_PUT_FIRST:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_value_next      = first_value_reg;
                    out_run_last_next   = 1'b0;
                    out_overflowed_next = overflow_flag_reg;
                    state_next          = fdsf_pkg::ST_PUT_SECOND;
                end
            end

            fdsf_pkg::ST_PUT_SECOND:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_value_next      = item_value_reg;
                    out_run_last_next   = 1'b1;
                    out_overflowed_next = overflow_flag_reg;
                    if (item_last_reg)
                    begin
                        seen_count_next    = '0;
                        dupe_found_next    = 1'b0;
                        dupe_key_next      = '0;
                        overflow_flag_next = 1'b0;
                    end
                    state_next = fdsf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fdsf_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Controller registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= fdsf_pkg::ST_IDLE;
            seen_count_reg    <= '0;
            dupe_found_reg    <= 1'b0;
            dupe_key_reg      <= '0;
            overflow_flag_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            seen_count_reg    <= seen_count_next;
            dupe_found_reg    <= dupe_found_next;
            dupe_key_reg      <= dupe_key_next;
            overflow_flag_reg <= overflow_flag_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_value_reg     <= item_value_next;
        item_last_reg      <= item_last_next;
        first_value_reg    <= first_value_next;
        out_value_reg      <= out_value_next;
        out_run_last_reg   <= out_run_last_next;
        out_overflowed_reg <= out_overflowed_next;
    end

    // ------------------------------------------------------------------
    // Outputs: fit the value to the 32-bit result field
    // ------------------------------------------------------------------
    for (genvar b = 0; b < 32; b++)
    begin : g_out_value
        if (b < VALUE_WIDTH)
        begin : g_in
            assign out_value[b] = out_value_reg[b];
        end
        else
        begin : g_out
            assign out_value[b] = 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign run_last   = out_run_last_reg;
    assign overflowed = out_overflowed_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A probe leaves the row only while the controller waits for it
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_s[STORE_DEPTH].valid |-> (state_reg == fdsf_pkg::ST_SCAN))
        else $error("probe left the row outside a scan");

    // The fill count never passes the row length
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_count_reg <= CNT_W'(STORE_DEPTH))
        else $error("fill count beyond row length");

    // Overflow is only flagged once every cell is filled
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_flag_reg |-> (seen_count_reg == CNT_W'(STORE_DEPTH)))
        else $error("overflow flagged with free cells");

    // A result is only produced with a duplicate latched
    a_put_needs_dupe: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fdsf_pkg::ST_PUT_FIRST) || (state_reg == fdsf_pkg::ST_PUT_SECOND))
        |-> dupe_found_reg)
        else $error("result pending without a latched duplicate");

    // Once the first result of a match is sent, the second result is next in line
    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fdsf_pkg::ST_PUT_FIRST) && out_free)
        |=> (state_reg == fdsf_pkg::ST_PUT_SECOND) && out_valid_reg && !out_run_last_reg)
        else $error("first result of a match not sent");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the first-duplicate stream filter.
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned DEPTH          = 64;
    localparam int unsigned VWIDTH         = 32;
    // An item with no duplicate known walks the whole row of cells; allow a margin on top.
    localparam int          SCAN_CYCLES    = DEPTH + 4;
    localparam int          DRAIN_LIMIT    = 50_000;
    localparam int          CYCLE_LIMIT    = 2_000_000;
    localparam int          ITEM_TARGET    = 2000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          MASK_REG_IDX   = int'(fdsf_pkg::REG_KEY_MASK);
    localparam int          UNUSED_REG_IDX = 1;
    localparam int          MAX_PRINTS     = 30;

    // One result as it leaves the block.
    typedef struct packed {
        logic [31:0] dup_value;
        logic        run_last;
        logic        overflowed;
    } dup_result_t;

    logic                            clk        = 1'b0;
    logic                            rst_n      = 1'b0;
    logic                            psel       = 1'b0;
    logic                            penable    = 1'b0;
    logic                            pwrite     = 1'b0;
    logic [fdsf_pkg::REG_ADDR_W-1:0] paddr      = '0;
    logic [31:0]                     pwdata     = '0;
    logic [31:0]                     prdata;
    logic                            pready;
    logic                            in_valid   = 1'b0;
    logic                            in_stall;
    logic [VWIDTH-1:0]               value      = '0;
    logic                            seq_last   = 1'b0;
    logic                            out_valid;
    logic                            out_stall  = 1'b0;
    logic [31:0]                     out_value;
    logic                            run_last;
    logic                            overflowed;

    // Own copy of the filter state, advanced once per accepted item.
    logic [31:0]           seen_vals [DEPTH];
    int unsigned           seen_fill     = 0;
    bit                    dup_latched   = 1'b0;
    logic [31:0]           latched_key   = '0;
    bit                    store_overrun = 1'b0;
    logic [31:0]           mask_cfg      = fdsf_pkg::KEY_MASK_RESET;

    // Duplicates predicted but not yet seen on the output, oldest first.
    dup_result_t           expected_dups [$];

    // Idling controls, set only at a falling edge; the hold count runs down at rising edges.
    bit                    tx_idling    = 1'b1;
    bit                    rx_idling    = 1'b1;
    int                    rx_hold_left = 0;

    int                    fault_count   = 0;
    int                    items_sent    = 0;
    int                    seqs_closed   = 0;
    int                    results_seen  = 0;
    int                    overrun_seen  = 0;
    int                    mask_writes   = 0;
    int                    cycle_count   = 0;

    first_duplicate_stream_filter #(
        .STORE_DEPTH (DEPTH),
        .VALUE_WIDTH (VWIDTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .seq_last   (seq_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_value  (out_value),
        .run_last   (run_last),
        .overflowed (overflowed)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Guard against a hang anywhere in the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run stopped by cycle limit at cycle %0d", cycle_count);
            $display("tb_top: errors");
            $finish;
        end
    end

    // Print one line per fault, up to a cap, and count every one.
    task automatic report_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Append one predicted result at the tail of the queue.
    task automatic queue_result(input logic [31:0] v, input logic last, input logic ovf);
        dup_result_t r;
        r = '{v, last, ovf};
        expected_dups.insert(expected_dups.size(), r);
    endtask

    // Work out the results one item causes and advance the predicted state.
    // Keys are compared under the mask in force when the item is accepted; the latched
    // key keeps the mask of the moment of discovery but is re-masked on every compare.
    task automatic predict_duplicates(input logic [31:0] v, input logic last);
        logic [31:0] key;
        bit          hit;
        int unsigned hit_idx;
        key     = v & mask_cfg;
        hit     = 1'b0;
        hit_idx = 0;
        if (dup_latched)
        begin
            if (key == (latched_key & mask_cfg))
                queue_result(v, 1'b1, store_overrun);
        end
        else
        begin
            // Earliest stored entry wins when several match.
            for (int unsigned i = 0; i < seen_fill; i++)
            begin
                if (!hit && (seen_vals[i] & mask_cfg) == key)
                begin
                    hit     = 1'b1;
                    hit_idx = i;
                end
            end
            if (hit)
            begin
                dup_latched = 1'b1;
                latched_key = key;
                queue_result(seen_vals[hit_idx], 1'b0, store_overrun);
                queue_result(v, 1'b1, store_overrun);
            end
            else if (seen_fill < DEPTH)
            begin
                seen_vals[seen_fill] = v;
                seen_fill++;
            end
            else
                store_overrun = 1'b1;
        end
        // End of sequence: drop everything but the mask.
        if (last)
        begin
            seen_fill     = 0;
            dup_latched   = 1'b0;
            latched_key   = '0;
            store_overrun = 1'b0;
        end
    endtask

    // Offer one item and hold it until the block takes it. Enter and leave on a rising
    // edge; valid stays high so that a following item can go out without a gap.
    task automatic send_item(input logic [31:0] v, input logic last);
        in_valid <= 1'b1;
        value    <= v;
        seq_last <= last;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        predict_duplicates(v, last);
        items_sent++;
        if (last)
            seqs_closed++;
    endtask

    // Drop valid for a random while, now and then for longer than a full scan.
    task automatic sender_gap();
        int n;
        if (tx_idling && $urandom_range(99) < 30)
        begin
            n = ($urandom_range(7) == 0) ? $urandom_range(4, 80) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold the sender until every predicted result has come, then let any item that
    // causes no result finish its scan.
    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_dups.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SCAN_CYCLES) @(posedge clk);
    endtask

    // Change idling behaviour between phases; lower valid first so no stale item is taken.
    task automatic set_idling(input bit tx, input bit rx);
        in_valid <= 1'b0;
        @(negedge clk);
        tx_idling = tx;
        rx_idling = rx;
        @(posedge clk);
    endtask

    // Register write: setup cycle, then access until pready. Only call while idle.
    task automatic cfg_write(input int idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fdsf_pkg::REG_ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == MASK_REG_IDX)
        begin
            mask_cfg = data;
            mask_writes++;
        end
        @(posedge clk);
    endtask

    task automatic cfg_read(input int idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= fdsf_pkg::REG_ADDR_W'(idx * 4);
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        data = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            2:       return 32'h0000_00FF;
            3:       return 32'hFFFF_0000;
            4:       return 32'h1 << $urandom_range(31);
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random stall, a free-running stretch, or a long counted hold-off.
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_idling)
            out_stall <= ($urandom_range(99) < 30);
        else
            out_stall <= 1'b0;
    end

    // Result check: sample mid-cycle, where valid, stall and payload are settled for the
    // coming edge at which the result is taken.
    always @(negedge clk)
    begin : check_results
        dup_result_t head;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (overflowed === 1'b1)
                overrun_seen++;
            if (expected_dups.size() == 0)
                report_fault($sformatf("result %h with nothing expected", out_value));
            else
            begin
                head = expected_dups.pop_front();
                if (out_value !== head.dup_value)
                    report_fault($sformatf("out_value %h, want %h", out_value, head.dup_value));
                if (run_last !== head.run_last)
                    report_fault($sformatf("run_last %b, want %b on %h",
                                           run_last, head.run_last, head.dup_value));
                if (overflowed !== head.overflowed)
                    report_fault($sformatf("overflowed %b, want %b on %h",
                                           overflowed, head.overflowed, head.dup_value));
            end
        end
    end

    // Reset value, readback, and a write to an index that holds no register.
    task automatic test_register_port();
        logic [31:0] rd;
        cfg_read(MASK_REG_IDX, rd);
        if (rd !== fdsf_pkg::KEY_MASK_RESET)
            report_fault($sformatf("key_mask after reset %h", rd));
        cfg_write(UNUSED_REG_IDX, 32'h0000_0000);
        cfg_read(MASK_REG_IDX, rd);
        if (rd !== mask_cfg)
            report_fault($sformatf("key_mask %h after spare write, want %h", rd, mask_cfg));
        cfg_write(MASK_REG_IDX, 32'h0F0F_0F0F);
        cfg_read(MASK_REG_IDX, rd);
        if (rd !== 32'h0F0F_0F0F)
            report_fault($sformatf("key_mask readback %h", rd));
        cfg_write(MASK_REG_IDX, 32'hFFFF_FFFF);
    endtask

    // Field extremes, first match, later matches, non-matching values after a match,
    // match on the closing item and a one-item sequence.
    task automatic test_basic_sequences();
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'h8000_0001, 1'b1);
        wait_drained();
    endtask

    // Empty mask, mask changed after a match, and several stored matches.
    task automatic test_key_mask_cases();
        cfg_write(MASK_REG_IDX, 32'h0000_0000);
        send_item(32'h0000_1234, 1'b0);
        send_item(32'h0000_ABCD, 1'b0);
        send_item(32'h0000_5555, 1'b1);
        wait_drained();

        // Latch key 1 under a nibble mask, then widen it mid-sequence.
        cfg_write(MASK_REG_IDX, 32'h0000_000F);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h0000_0011, 1'b0);
        wait_drained();
        cfg_write(MASK_REG_IDX, 32'h0000_00FF);
        send_item(32'h0000_0011, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h0000_0021, 1'b1);
        wait_drained();

        // Store two distinct values, then narrow the mask so both match the next one.
        cfg_write(MASK_REG_IDX, 32'hFFFF_FFFF);
        send_item(32'h0000_0010, 1'b0);
        send_item(32'h0000_0011, 1'b0);
        wait_drained();
        cfg_write(MASK_REG_IDX, 32'h0000_00F0);
        send_item(32'h0000_0012, 1'b1);
        wait_drained();
        cfg_write(MASK_REG_IDX, 32'hFFFF_FFFF);
    endtask

    // Fill the store past its depth, match an early entry, then check that a new
    // sequence starts with the flag clear.
    task automatic test_store_full();
        logic [31:0] stored [DEPTH + 6];
        logic [31:0] v;
        for (int i = 0; i < DEPTH + 6; i++)
        begin
            stored[i] = ($urandom() & 32'hFFFF_FF00) | 32'(i);
            sender_gap();
            send_item(stored[i], 1'b0);
        end
        send_item(stored[5], 1'b0);
        send_item(stored[5], 1'b1);

        // Overrun with no match at all before the sequence closes.
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            sender_gap();
            send_item(($urandom() & 32'hFFFF_FF00) | 32'(i), i == DEPTH + 1);
        end
        v = $urandom();
        send_item(v, 1'b0);
        send_item(v, 1'b1);
        wait_drained();
    endtask

    // Hold the receiver off while a run of matching items keeps coming, so the block
    // backs up and stalls its input; then pause until all results are out.
    task automatic test_backpressure();
        logic [15:0] k;
        k = $urandom();
        set_idling(1'b0, 1'b1);
        cfg_write(MASK_REG_IDX, 32'h0000_FFFF);
        @(negedge clk);
        rx_hold_left = HOLD_CYCLES;
        @(posedge clk);
        send_item({16'($urandom()), k}, 1'b0);
        send_item({16'($urandom()), k}, 1'b0);
        for (int i = 0; i < 36; i++)
        begin
            if (i % 7 == 3)
                send_item({16'($urandom()), k ^ 16'h0001}, 1'b0);
            else
                send_item({16'($urandom()), k}, i == 35);
        end
        wait_drained();
        set_idling(1'b1, 1'b1);
        cfg_write(MASK_REG_IDX, 32'hFFFF_FFFF);
    endtask

    // One sequence with random content. Short ones draw mostly from a small pool so
    // matches are likely; long ones are mostly fresh values to overrun the store.
    // A few are left open so the next sequence carries on from their state.
    task automatic send_random_sequence(input bit allow_long);
        logic [31:0] pool [4];
        logic [31:0] v;
        bit          long_seq;
        bit          close_seq;
        int          len;
        int          pick;
        long_seq  = allow_long && ($urandom_range(11) == 0);
        len       = long_seq ? $urandom_range(DEPTH, DEPTH + 20) : $urandom_range(1, 24);
        close_seq = ($urandom_range(9) != 0);
        for (int i = 0; i < 4; i++)
            pool[i] = $urandom();
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (long_seq)
                v = (pick < 3) ? pool[0] : $urandom();
            else if (pick < 55)
                v = pool[$urandom_range(3)] ^ ($urandom() & ~mask_cfg);
            else
                v = $urandom();
            // Now and then change the mask in the middle of a sequence.
            if (!long_seq && i > 0 && $urandom_range(39) == 0)
            begin
                wait_drained();
                cfg_write(MASK_REG_IDX, pick_mask());
            end
            sender_gap();
            send_item(v, close_seq && i == len - 1);
        end
    endtask

    // A stretch with neither side idling.
    task automatic test_full_rate();
        int start;
        start = items_sent;
        set_idling(1'b0, 1'b0);
        while (items_sent - start < 300)
            send_random_sequence(1'b0);
        wait_drained();
        set_idling(1'b1, 1'b1);
    endtask

    // Bulk of the run: random sequences with the mask changed between some of them.
    task automatic test_random_sequences();
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(3) == 0)
            begin
                wait_drained();
                cfg_write(MASK_REG_IDX, pick_mask());
            end
            send_random_sequence(1'b1);
        end
        wait_drained();
    endtask

    initial
    begin
        // Hold reset, then release it on an edge.
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_port();
        test_basic_sequences();
        test_key_mask_cases();
        test_store_full();
        test_backpressure();
        test_full_rate();
        test_random_sequences();

        wait_drained();
        if (expected_dups.size() != 0)
            report_fault($sformatf("%0d expected results never came", expected_dups.size()));

        $display("covered: %0d items in %0d closed sequences, %0d results checked",
                 items_sent, seqs_closed, results_seen);
        $display("covered: %0d results after store overrun, %0d key mask writes",
                 overrun_seen, mask_writes);
        if (fault_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

/* first_duplicate_stream_filter.f */
rtl/fdsf_pkg.sv
rtl/fdsf_cell.sv
rtl/first_duplicate_stream_filter.sv
tb/tb_top.sv
